>>> rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants for the disjoint-set union engine
// Field widths, operation codes, table entry layout and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int ElemW   = 10;
  localparam int OpW     = 2;
  localparam int RankW   = 4;
  localparam int CountW  = 11;
  localparam int DataW   = 32;
  localparam int PaddrW  = 3;
  localparam int RegIdxW = 1;

  localparam int DefaultMaxElements = 1024;

  localparam logic [CountW-1:0]  CountReset       = 11'd1024;
  localparam logic [RegIdxW-1:0] RegElementCount  = 1'd0;
  localparam logic [RankW-1:0]   RankMax          = 4'd15;

  localparam logic [OpW-1:0] OpFind  = 2'd0;
  localparam logic [OpW-1:0] OpUnite = 2'd1;
  localparam logic [OpW-1:0] OpSame  = 2'd2;
  localparam logic [OpW-1:0] OpNone  = 2'd3;

  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_READ,
    MEM_WRITE
  } dsu_mem_e;

  typedef enum logic [2:0] {
    ADDR_CLEAR,
    ADDR_START,
    ADDR_CUR,
    ADDR_NEXT,
    ADDR_RA,
    ADDR_RB
  } dsu_addr_e;

  typedef enum logic [2:0] {
    WD_CLEAR,
    WD_COMPRESS,
    WD_A_UNDER_B,
    WD_B_UNDER_A,
    WD_RANK_UP
  } dsu_wdata_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_START,
    CUR_NEXT
  } dsu_cur_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_BAD,
    RES_FIND,
    RES_SAME,
    RES_UNITE
  } dsu_res_e;

  // One table word: parent link, root mark, rank.
  typedef struct packed {
    logic [ElemW-1:0] parent;
    logic             root;
    logic [RankW-1:0] rank;
  } dsu_entry_t;

  typedef struct packed {
    logic       load_item;
    dsu_mem_e   mem_op;
    dsu_addr_e  addr_sel;
    dsu_wdata_e wdata_sel;
    dsu_cur_e   cur_sel;
    logic       side_b;
    logic       capture_root;
    logic       clear_step;
    logic       res_load;
    dsu_res_e   res_kind;
  } dsu_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           bad;
    logic           root_hit;
    logic           same_root;
    logic           rank_lt;
    logic           rank_eq;
    logic           rank_a_max;
    logic           clear_last;
  } dsu_status_t;

endpackage

>>> rtl/dsu_stream_if.sv
// ----------------------------------------------------------------------------
// dsu_stream_if: valid/ready channels of the disjoint-set union engine
// Request channel (operation and two element indices) and result channel.
// ----------------------------------------------------------------------------
interface dsu_in_if;
  logic                      valid;
  logic                      ready;
  logic [dsu_pkg::OpW-1:0]   op;
  logic [dsu_pkg::ElemW-1:0] elem_a;
  logic [dsu_pkg::ElemW-1:0] elem_b;

  modport source (output valid, op, elem_a, elem_b, input ready);
  modport sink   (input valid, op, elem_a, elem_b, output ready);
endinterface

interface dsu_out_if;
  logic                      valid;
  logic                      ready;
  logic [dsu_pkg::ElemW-1:0] root_a;
  logic                      flag;
  logic                      bad_index;

  modport source (output valid, root_a, flag, bad_index, input ready);
  modport sink   (input valid, root_a, flag, bad_index, output ready);
endinterface

>>> rtl/dsu_datapath.sv
// ----------------------------------------------------------------------------
// dsu_datapath: table memory, walk pointer and result registers
// Single-port table of {parent, root, rank} words with registered read,
// driven step by step by the controller.
// ----------------------------------------------------------------------------
module dsu_datapath #(
  parameter int MaxElements = dsu_pkg::DefaultMaxElements
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dsu_pkg::dsu_cmd_t            cmd_i,
  output dsu_pkg::dsu_status_t         status_o,
  input  logic [dsu_pkg::OpW-1:0]      op_i,
  input  logic [dsu_pkg::ElemW-1:0]    elem_a_i,
  input  logic [dsu_pkg::ElemW-1:0]    elem_b_i,
  input  logic [dsu_pkg::CountW-1:0]   count_i,
  output logic [dsu_pkg::ElemW-1:0]    root_a_o,
  output logic                         flag_o,
  output logic                         bad_index_o
);

  localparam int AW = $clog2(MaxElements);
  localparam logic [16:0]   MaxLimit = 17'(MaxElements);
  localparam logic [AW-1:0] LastAddr = AW'(MaxElements - 1);

  dsu_pkg::dsu_entry_t mem [MaxElements];
  dsu_pkg::dsu_entry_t rd_q;
  dsu_pkg::dsu_entry_t wdata;

  logic [dsu_pkg::OpW-1:0]   op_q;
  logic [dsu_pkg::ElemW-1:0] a_q, b_q;
  logic                      bad_q;
  logic [AW-1:0]             cur_q, ra_q, rb_q, clr_q;
  logic [dsu_pkg::RankW-1:0] rank_a_q, rank_b_q;
  logic [AW-1:0]             start_addr, next_addr, addr;
  logic                      a_bad, b_bad;
  logic [dsu_pkg::ElemW-1:0] root_q;
  logic                      flag_q, badf_q;

  // Range check against min(count, MaxElements).
  assign a_bad = ({1'b0, elem_a_i} >= count_i) || (17'(elem_a_i) >= MaxLimit);
  assign b_bad = ({1'b0, elem_b_i} >= count_i) || (17'(elem_b_i) >= MaxLimit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= op_i;
      a_q   <= elem_a_i;
      b_q   <= elem_b_i;
      bad_q <= a_bad || ((op_i != dsu_pkg::OpFind) && b_bad);
    end
  end

  assign start_addr = cmd_i.side_b ? AW'(b_q) : AW'(a_q);
  assign next_addr  = AW'(rd_q.parent);

  always_comb begin
    case (cmd_i.addr_sel)
      dsu_pkg::ADDR_CLEAR: addr = clr_q;
      dsu_pkg::ADDR_START: addr = start_addr;
      dsu_pkg::ADDR_CUR:   addr = cur_q;
      dsu_pkg::ADDR_NEXT:  addr = next_addr;
      dsu_pkg::ADDR_RA:    addr = ra_q;
      dsu_pkg::ADDR_RB:    addr = rb_q;
      default:             addr = cur_q;
    endcase
  end

  always_comb begin
    wdata = '0;
    case (cmd_i.wdata_sel)
      dsu_pkg::WD_CLEAR: begin
        wdata.root = 1'b1;
      end
      dsu_pkg::WD_COMPRESS: begin
        wdata.parent = cmd_i.side_b ? dsu_pkg::ElemW'(rb_q) : dsu_pkg::ElemW'(ra_q);
        wdata.rank   = rd_q.rank;
      end
      dsu_pkg::WD_A_UNDER_B: begin
        wdata.parent = dsu_pkg::ElemW'(rb_q);
        wdata.rank   = rank_a_q;
      end
      dsu_pkg::WD_B_UNDER_A: begin
        wdata.parent = dsu_pkg::ElemW'(ra_q);
        wdata.rank   = rank_b_q;
      end
      dsu_pkg::WD_RANK_UP: begin
        wdata.root = 1'b1;
        wdata.rank = rank_a_q + 1'b1;
      end
      default: wdata = '0;
    endcase
  end

  // Single port: one read or one write per cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.mem_op)
      dsu_pkg::MEM_WRITE: mem[addr] <= wdata;
      dsu_pkg::MEM_READ:  rd_q <= mem[addr];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cur_sel)
      dsu_pkg::CUR_START: cur_q <= start_addr;
      dsu_pkg::CUR_NEXT:  cur_q <= next_addr;
      default: ;
    endcase
    if (cmd_i.capture_root) begin
      if (cmd_i.side_b) begin
        rb_q     <= cur_q;
        rank_b_q <= rd_q.rank;
      end else begin
        ra_q     <= cur_q;
        rank_a_q <= rd_q.rank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      root_q <= '0;
      flag_q <= 1'b0;
      badf_q <= 1'b0;
      case (cmd_i.res_kind)
        dsu_pkg::RES_BAD:  badf_q <= 1'b1;
        dsu_pkg::RES_FIND: root_q <= dsu_pkg::ElemW'(ra_q);
        dsu_pkg::RES_SAME: begin
          root_q <= dsu_pkg::ElemW'(ra_q);
          flag_q <= (ra_q == rb_q);
        end
        dsu_pkg::RES_UNITE: begin
          flag_q <= (ra_q != rb_q);
          root_q <= ((ra_q != rb_q) && (rank_a_q < rank_b_q)) ?
                    dsu_pkg::ElemW'(rb_q) : dsu_pkg::ElemW'(ra_q);
        end
        default: ;
      endcase
    end
  end

  assign root_a_o    = root_q;
  assign flag_o      = flag_q;
  assign bad_index_o = badf_q;

  assign status_o.op         = op_q;
  assign status_o.bad        = bad_q;
  assign status_o.root_hit   = rd_q.root;
  assign status_o.same_root  = (ra_q == rb_q);
  assign status_o.rank_lt    = (rank_a_q < rank_b_q);
  assign status_o.rank_eq    = (rank_a_q == rank_b_q);
  assign status_o.rank_a_max = (rank_a_q == dsu_pkg::RankMax);
  assign status_o.clear_last = (clr_q == LastAddr);

endmodule

>>> rtl/dsu_ctrl.sv
// ----------------------------------------------------------------------------
// dsu_ctrl: sequencer of the disjoint-set union engine
// Clear sweep, root walk, compression pass, merge writes and result handoff.
// ----------------------------------------------------------------------------
module dsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dsu_pkg::dsu_status_t status_i,
  output dsu_pkg::dsu_cmd_t    cmd_o
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_WALK_RD = 4'd3;
  localparam logic [3:0] S_WALK    = 4'd4;
  localparam logic [3:0] S_COMP_RD = 4'd5;
  localparam logic [3:0] S_COMP    = 4'd6;
  localparam logic [3:0] S_MERGE   = 4'd7;
  localparam logic [3:0] S_RANK_UP = 4'd8;
  localparam logic [3:0] S_RESULT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       side_b_q, side_b_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d  = state_q;
    side_b_d = side_b_q;
    cmd_o    = '0;
    cmd_o.side_b = side_b_q;

    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_op     = dsu_pkg::MEM_WRITE;
        cmd_o.addr_sel   = dsu_pkg::ADDR_CLEAR;
        cmd_o.wdata_sel  = dsu_pkg::WD_CLEAR;
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        side_b_d = 1'b0;
        if ((status_i.op == dsu_pkg::OpNone) || status_i.bad) state_d = S_RESULT;
        else state_d = S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd_o.mem_op   = dsu_pkg::MEM_READ;
        cmd_o.addr_sel = dsu_pkg::ADDR_START;
        cmd_o.cur_sel  = dsu_pkg::CUR_START;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.mem_op = dsu_pkg::MEM_READ;
        if (status_i.root_hit) begin
          // root found: latch it and restart from the start for compression
          cmd_o.capture_root = 1'b1;
          cmd_o.addr_sel     = dsu_pkg::ADDR_START;
          cmd_o.cur_sel      = dsu_pkg::CUR_START;
          state_d = S_COMP;
        end else begin
          cmd_o.addr_sel = dsu_pkg::ADDR_NEXT;
          cmd_o.cur_sel  = dsu_pkg::CUR_NEXT;
        end
      end
      S_COMP: begin
        if (!status_i.root_hit) begin
          cmd_o.mem_op    = dsu_pkg::MEM_WRITE;
          cmd_o.addr_sel  = dsu_pkg::ADDR_CUR;
          cmd_o.wdata_sel = dsu_pkg::WD_COMPRESS;
          cmd_o.cur_sel   = dsu_pkg::CUR_NEXT;
          state_d = S_COMP_RD;
        end else if (!side_b_q && (status_i.op != dsu_pkg::OpFind)) begin
          side_b_d = 1'b1;
          state_d  = S_WALK_RD;
        end else if ((status_i.op == dsu_pkg::OpUnite) && !status_i.same_root) begin
          state_d = S_MERGE;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_COMP_RD: begin
        cmd_o.mem_op   = dsu_pkg::MEM_READ;
        cmd_o.addr_sel = dsu_pkg::ADDR_CUR;
        state_d = S_COMP;
      end
      S_MERGE: begin
        cmd_o.mem_op = dsu_pkg::MEM_WRITE;
        if (status_i.rank_lt) begin
          cmd_o.addr_sel  = dsu_pkg::ADDR_RA;
          cmd_o.wdata_sel = dsu_pkg::WD_A_UNDER_B;
          state_d = S_RESULT;
        end else begin
          cmd_o.addr_sel  = dsu_pkg::ADDR_RB;
          cmd_o.wdata_sel = dsu_pkg::WD_B_UNDER_A;
          if (status_i.rank_eq && !status_i.rank_a_max) state_d = S_RANK_UP;
          else state_d = S_RESULT;
        end
      end
      S_RANK_UP: begin
        cmd_o.mem_op    = dsu_pkg::MEM_WRITE;
        cmd_o.addr_sel  = dsu_pkg::ADDR_RA;
        cmd_o.wdata_sel = dsu_pkg::WD_RANK_UP;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          if (status_i.op == dsu_pkg::OpNone) cmd_o.res_kind = dsu_pkg::RES_ZERO;
          else if (status_i.bad) cmd_o.res_kind = dsu_pkg::RES_BAD;
          else if (status_i.op == dsu_pkg::OpFind) cmd_o.res_kind = dsu_pkg::RES_FIND;
          else if (status_i.op == dsu_pkg::OpSame) cmd_o.res_kind = dsu_pkg::RES_SAME;
          else cmd_o.res_kind = dsu_pkg::RES_UNITE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      side_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_b_q    <= side_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/disjoint_set_union_engine.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_engine: union-find with path compression, union by rank
// Top level: configuration register, APB-style port, controller and datapath.
// ----------------------------------------------------------------------------
// After reset the engine first sweeps its table, one entry per cycle, over
// all MaxElements entries (1024 by default); no request is taken until the
// sweep ends, though the element_count register can be written meanwhile.
// Each request (find, unite, same) is then worked on alone. The table sits
// in one single-port memory with registered read, and that port sets the
// pace: a root walk reads one link after another, and the compression pass
// reads each link, then rewrites it. A unite adds up to two merge writes; a
// rejected index or an unused opcode skips the walk. The result waits in an
// output register, so the next request can be accepted while it is unread.
// ----------------------------------------------------------------------------
module disjoint_set_union_engine #(
  parameter int MaxElements = dsu_pkg::DefaultMaxElements
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dsu_in_if.sink                       in_i,
  dsu_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsu_pkg::PaddrW-1:0]   paddr,
  input  logic [dsu_pkg::DataW-1:0]    pwdata,
  output logic [dsu_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  dsu_pkg::dsu_cmd_t    cmd;
  dsu_pkg::dsu_status_t status;

  logic [dsu_pkg::CountW-1:0]  count_q, count_d;
  logic [dsu_pkg::RegIdxW-1:0] reg_idx;
  logic                        cfg_wr;

  // Register index is the word address; byte offset bits are ignored.
  assign reg_idx = paddr[dsu_pkg::PaddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    count_d = count_q;
    if (cfg_wr && (reg_idx == dsu_pkg::RegElementCount)) begin
      count_d = pwdata[dsu_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= dsu_pkg::CountReset;
    end else begin
      count_q <= count_d;
    end
  end

  assign prdata = (reg_idx == dsu_pkg::RegElementCount) ?
                  dsu_pkg::DataW'(count_q) : '0;

  // Sequencer: owns the handshakes and steps the datapath.
  dsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Table memory, walk pointer, captured roots and result registers.
  dsu_datapath #(
    .MaxElements (MaxElements)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (in_i.op),
    .elem_a_i    (in_i.elem_a),
    .elem_b_i    (in_i.elem_b),
    .count_i     (count_q),
    .root_a_o    (out_o.root_a),
    .flag_o      (out_o.flag),
    .bad_index_o (out_o.bad_index)
  );

endmodule
